FILE: sv/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types, constants and the control program of the pulse rate tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

  // Default parameter values
  localparam int FRAME_INDEX_WIDTH_DEF  = 24;
  localparam int RATE_FRACTION_BITS_DEF = 8;

  // Fixed field widths
  localparam int RATE_W       = 22;
  localparam int SIGNAL_W     = 2;
  localparam int FRAME_RATE_W = 8;
  localparam int FIRST_W      = 2;
  localparam int IND_W        = 4;
  localparam int WEIGHT_W     = 16;
  localparam int PERIOD_W     = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 22;

  // 60 * 255 fits in this many bits
  localparam int RATE_SCALE_W       = 14;
  localparam int SECONDS_PER_MINUTE = 60;

  localparam logic [RATE_W-1:0]   RATE_MAX    = '1;
  localparam logic [SIGNAL_W-1:0] SIGNAL_PEAK = 2'b01;

  // Register reset values
  localparam logic [FRAME_RATE_W-1:0] FRAME_RATE_RST       = 8'd30;
  localparam logic [RATE_W-1:0]       MIN_RATE_RST         = 22'd10240;
  localparam logic [RATE_W-1:0]       MAX_RATE_RST         = 22'd46080;
  localparam logic [FIRST_W-1:0]      FIRST_EDGE_FRAME_RST = 2'd2;
  localparam logic [IND_W-1:0]        INDICATOR_FRAMES_RST = 4'd5;
  localparam logic [WEIGHT_W-1:0]     AVERAGE_WEIGHT_RST   = 16'd655;
  localparam logic [PERIOD_W-1:0]     DISPLAY_PERIOD_RST   = 16'd60;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_RATE       = 3'd0,
    REG_MIN_RATE         = 3'd1,
    REG_MAX_RATE         = 3'd2,
    REG_FIRST_EDGE_FRAME = 3'd3,
    REG_INDICATOR_FRAMES = 3'd4,
    REG_AVERAGE_WEIGHT   = 3'd5,
    REG_DISPLAY_PERIOD   = 3'd6
  } cfg_reg_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_CAPTURE  = 4'd1,
    OP_DIV_INIT = 4'd2,
    OP_DIV_STEP = 4'd3,
    OP_JUDGE    = 4'd4,
    OP_ACCEPT   = 4'd5,
    OP_AVG_ADD  = 4'd6,
    OP_FIRST    = 4'd7,
    OP_FINISH   = 4'd8
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    COND_NEVER     = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_NO_ACCEPT = 4'd2,
    COND_NO_EDGE   = 4'd3,
    COND_NO_HAVE   = 4'd4,
    COND_DIV_MORE  = 4'd5,
    COND_REJECT    = 4'd6,
    COND_NO_AVG    = 4'd7,
    COND_OUT_BUSY  = 4'd8
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_CAPTURE  = 4'd0;
  localparam step_t STEP_CHECK    = 4'd1;
  localparam step_t STEP_HAVE     = 4'd2;
  localparam step_t STEP_DIV_INIT = 4'd3;
  localparam step_t STEP_DIV_STEP = 4'd4;
  localparam step_t STEP_JUDGE    = 4'd5;
  localparam step_t STEP_ACCEPT   = 4'd6;
  localparam step_t STEP_AVG_ADD  = 4'd7;
  localparam step_t STEP_FIRST    = 4'd8;
  localparam step_t STEP_FINISH   = 4'd9;
  localparam step_t STEP_RETURN   = 4'd10;
  localparam step_t STEP_LAST     = STEP_RETURN;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic edge_found;
    logic have_edge;
    logic div_more;
    logic reject;
    logic avg_ready;
    logic out_busy;
  } status_t;

  // Control store: one control word per step
  function automatic ctrl_t ucode(step_t step);
    ctrl_t word;
    word = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_CAPTURE};
    case (step)
      STEP_CAPTURE:  word = '{op: OP_CAPTURE,  cond: COND_NO_ACCEPT, target: STEP_CAPTURE};
      STEP_CHECK:    word = '{op: OP_NOP,      cond: COND_NO_EDGE,   target: STEP_FINISH};
      STEP_HAVE:     word = '{op: OP_NOP,      cond: COND_NO_HAVE,   target: STEP_FIRST};
      STEP_DIV_INIT: word = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: STEP_CAPTURE};
      STEP_DIV_STEP: word = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,  target: STEP_DIV_STEP};
      STEP_JUDGE:    word = '{op: OP_JUDGE,    cond: COND_REJECT,    target: STEP_FINISH};
      STEP_ACCEPT:   word = '{op: OP_ACCEPT,   cond: COND_NO_AVG,    target: STEP_FINISH};
      STEP_AVG_ADD:  word = '{op: OP_AVG_ADD,  cond: COND_ALWAYS,    target: STEP_FINISH};
      STEP_FIRST:    word = '{op: OP_FIRST,    cond: COND_NEVER,     target: STEP_CAPTURE};
      STEP_FINISH:   word = '{op: OP_FINISH,   cond: COND_OUT_BUSY,  target: STEP_FINISH};
      STEP_RETURN:   word = '{op: OP_NOP,      cond: COND_ALWAYS,    target: STEP_CAPTURE};
      default:       word = '{op: OP_NOP,      cond: COND_ALWAYS,    target: STEP_CAPTURE};
    endcase
    return word;
  endfunction

endpackage

FILE: sv/prt_in_if.sv
// ----------------------------------------------------------------------------
// prt_in_if
// Input channel: one pulse-detector value per video frame.
// ----------------------------------------------------------------------------
interface prt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [prt_pkg::SIGNAL_W-1:0]  peak_signal;

  modport source (output valid, output peak_signal, input ready);
  modport sink   (input valid, input peak_signal, output ready);
endinterface

FILE: sv/prt_out_if.sv
// ----------------------------------------------------------------------------
// prt_out_if
// Result channel: indicator, averaged and shown rate, edge flags per frame.
// ----------------------------------------------------------------------------
interface prt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          indicator_on;
  logic [prt_pkg::RATE_W-1:0]    rate_estimate;
  logic [prt_pkg::RATE_W-1:0]    shown_rate;
  logic                          shown_ready;
  logic                          edge_seen;
  logic                          edge_rejected;

  modport source (output valid, output indicator_on, output rate_estimate,
                  output shown_rate, output shown_ready, output edge_seen,
                  output edge_rejected, input ready);
  modport sink   (input valid, input indicator_on, input rate_estimate,
                  input shown_rate, input shown_ready, input edge_seen,
                  input edge_rejected, output ready);
endinterface

FILE: sv/pulse_rate_tracker_core.sv
// ----------------------------------------------------------------------------
// pulse_rate_tracker_core
// Per-frame pulse rate tracker: edge detection, rate by division, range
// check, exponential average, indicator countdown and display latch.
// ----------------------------------------------------------------------------
//  Channel      Direction  Transaction
//  pulse_in     in         one detector value (peak_signal) per frame
//  result_out   out        one result per frame: indicator, rates, edge flags
//  cfg_*        in         register write, one per cycle, no handshake
//
//  Each item runs capture, check, finish and return; the first edge adds the
//  seeding step, a later edge the divider, range check and, if accepted, the
//  accept step and, once seeded, the average update. The bit-serial divider
//  yields one quotient bit a cycle. A finished result waits in the output
//  register; the sequencer holds at its finish step while that register is
//  full and not taken, and takes the next item once back at its first step.
//  Synchronous reset: the program restarts, config and state take defaults.
// ----------------------------------------------------------------------------
module pulse_rate_tracker_core #(
  parameter int FRAME_INDEX_WIDTH  = prt_pkg::FRAME_INDEX_WIDTH_DEF,
  parameter int RATE_FRACTION_BITS = prt_pkg::RATE_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [prt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  prt_in_if.sink                           pulse_in,
  prt_out_if.source                        result_out
);
  import prt_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Control store and step counter
  prt_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Datapath
  prt_datapath #(
    .FRAME_INDEX_WIDTH  (FRAME_INDEX_WIDTH),
    .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .ctrl        (ctrl),
    .status      (status),
    .pulse_in    (pulse_in),
    .result_out  (result_out)
  );

endmodule

FILE: sv/prt_sequencer.sv
// ----------------------------------------------------------------------------
// prt_sequencer
// Step counter over the control store, with conditional jumps on status.
// ----------------------------------------------------------------------------
module prt_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  prt_pkg::status_t status,
  output prt_pkg::ctrl_t   ctrl
);
  import prt_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  take;

  // Fetch the control word of the current step
  assign ctrl = ucode(pc);

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_ACCEPT: take = !status.accept;
      COND_NO_EDGE:   take = !status.edge_found;
      COND_NO_HAVE:   take = !status.have_edge;
      COND_DIV_MORE:  take = status.div_more;
      COND_REJECT:    take = status.reject;
      COND_NO_AVG:    take = !status.avg_ready;
      COND_OUT_BUSY:  take = status.out_busy;
      default:        take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : step_t'(pc + 1'b1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_CAPTURE;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= STEP_LAST)
    else $error("step counter left the program");

  a_wait_for_item: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_CAPTURE && !status.accept) |=> pc == STEP_CAPTURE)
    else $error("sequencer moved on without an input transaction");
`endif

endmodule

FILE: sv/prt_datapath.sv
// ----------------------------------------------------------------------------
// prt_datapath
// Registers, bit-serial divider, average multiplier and result register,
// driven by the operation of the current control word; configuration by cfg_*.
// ----------------------------------------------------------------------------
module prt_datapath #(
  parameter int FRAME_INDEX_WIDTH  = prt_pkg::FRAME_INDEX_WIDTH_DEF,
  parameter int RATE_FRACTION_BITS = prt_pkg::RATE_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [prt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input  prt_pkg::ctrl_t                   ctrl,
  output prt_pkg::status_t                 status,
  prt_in_if.sink                           pulse_in,
  prt_out_if.source                        result_out
);
  import prt_pkg::*;

  localparam int FW     = FRAME_INDEX_WIDTH;
  localparam int NUM_W  = RATE_SCALE_W + RATE_FRACTION_BITS;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int QW     = (NUM_W > RATE_W) ? NUM_W : RATE_W;
  localparam int ACC_W  = WEIGHT_W + RATE_W + 1;
  localparam int INV_W  = WEIGHT_W + 1;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (WEIGHT_W - 1);
  localparam logic [INV_W-1:0] WEIGHT_ONE = INV_W'(1) << WEIGHT_W;

  // Configuration
  logic [FRAME_RATE_W-1:0] frame_rate;
  logic [RATE_W-1:0]       min_rate;
  logic [RATE_W-1:0]       max_rate;
  logic [FIRST_W-1:0]      first_edge_frame;
  logic [IND_W-1:0]        indicator_frames;
  logic [WEIGHT_W-1:0]     average_weight;
  logic [PERIOD_W-1:0]     display_period;

  // Tracker state
  logic [SIGNAL_W-1:0]     previous_signal;
  logic [FW-1:0]           frame_index;
  logic [FW-1:0]           last_edge_frame;
  logic                    have_edge;
  logic                    average_ready;
  logic [RATE_W-1:0]       rate_average;
  logic [IND_W-1:0]        indicator_count;
  logic [PERIOD_W-1:0]     display_phase;
  logic [RATE_W-1:0]       latched_rate;

  // Per-item working registers
  logic [SIGNAL_W-1:0]     cur_signal;
  logic                    edge_found;
  logic                    rejected;
  logic [RATE_W-1:0]       rate;
  logic [NUM_W-1:0]        dividend;
  logic [NUM_W-1:0]        quotient;
  logic [FW:0]             remainder;
  logic [FW-1:0]           divisor;
  logic [CNT_W-1:0]        div_count;
  logic [ACC_W-1:0]        acc;

  // Result register
  logic                    out_valid;
  logic                    o_indicator_on;
  logic [RATE_W-1:0]       o_rate_estimate;
  logic [RATE_W-1:0]       o_shown_rate;
  logic                    o_edge_seen;
  logic                    o_edge_rejected;

  logic                    accept;
  logic                    out_busy;
  logic                    finish;
  logic                    edge_now;
  logic [FW:0]             rem_shift;
  logic                    rem_fits;
  logic [QW-1:0]           q_ext;
  logic [RATE_W-1:0]       rate_sat;
  logic                    rate_bad;
  logic [INV_W-1:0]        inv_weight;
  logic [ACC_W-1:0]        avg_sum;
  logic [PERIOD_W-1:0]     period;
  logic [PERIOD_W:0]       phase_inc;
  logic [RATE_W-1:0]       latch_value;
  logic                    ind_on;
  logic [NUM_W-1:0]        numerator;

  // Handshakes
  assign pulse_in.ready = (ctrl.op == OP_CAPTURE);
  assign accept         = pulse_in.valid && pulse_in.ready;
  assign out_busy       = out_valid && !result_out.ready;
  assign finish         = (ctrl.op == OP_FINISH) && !out_busy;

  // Rising edge: previous not a peak, current a peak, frame far enough in
  assign edge_now = (frame_index >= FW'(first_edge_frame)) &&
                    (previous_signal != SIGNAL_PEAK) &&
                    (pulse_in.peak_signal == SIGNAL_PEAK);

  // One restoring division step
  assign rem_shift = {remainder[FW-1:0], dividend[NUM_W-1]};
  assign rem_fits  = rem_shift >= {1'b0, divisor};

  // Saturate the quotient; a zero interval saturates too
  assign q_ext    = QW'(quotient);
  assign rate_sat = (divisor == '0 || q_ext > QW'(RATE_MAX)) ? RATE_MAX
                                                             : q_ext[RATE_W-1:0];
  assign rate_bad = (rate_sat < min_rate) || (rate_sat > max_rate);

  // 60 * frame_rate scaled to the rate fraction
  assign numerator = (NUM_W'(frame_rate) * NUM_W'(SECONDS_PER_MINUTE))
                     << RATE_FRACTION_BITS;

  // Second half of the weighted average
  assign inv_weight = WEIGHT_ONE - INV_W'(average_weight);
  assign avg_sum    = acc + ACC_W'(inv_weight) * ACC_W'(rate_average) + ROUND_HALF;

  // Display period bookkeeping; a zero period latches every frame
  assign period      = (display_period == '0) ? PERIOD_W'(1) : display_period;
  assign phase_inc   = {1'b0, display_phase} + 1'b1;
  assign latch_value = (display_phase == '0) ? rate_average : latched_rate;
  assign ind_on      = (indicator_count != '0);

  assign status = '{accept:     accept,
                    edge_found: edge_found,
                    have_edge:  have_edge,
                    div_more:   (div_count > CNT_W'(1)),
                    reject:     rate_bad,
                    avg_ready:  average_ready,
                    out_busy:   out_busy};

  // Divider and multiplier working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_DIV_INIT: begin
        dividend  <= numerator;
        quotient  <= '0;
        remainder <= '0;
        divisor   <= frame_index - last_edge_frame;
        div_count <= CNT_W'(NUM_W);
      end
      OP_DIV_STEP: begin
        dividend  <= {dividend[NUM_W-2:0], 1'b0};
        quotient  <= {quotient[NUM_W-2:0], rem_fits};
        remainder <= rem_fits ? rem_shift - {1'b0, divisor} : rem_shift;
        div_count <= div_count - 1'b1;
      end
      OP_JUDGE: begin
        rate <= rate_sat;
      end
      OP_ACCEPT: begin
        acc <= ACC_W'(average_weight) * ACC_W'(rate);
      end
      default: begin
      end
    endcase
  end

  // Configuration, tracker state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rate       <= FRAME_RATE_RST;
      min_rate         <= MIN_RATE_RST;
      max_rate         <= MAX_RATE_RST;
      first_edge_frame <= FIRST_EDGE_FRAME_RST;
      indicator_frames <= INDICATOR_FRAMES_RST;
      average_weight   <= AVERAGE_WEIGHT_RST;
      display_period   <= DISPLAY_PERIOD_RST;
      previous_signal  <= '0;
      frame_index      <= '0;
      last_edge_frame  <= '0;
      have_edge        <= 1'b0;
      average_ready    <= 1'b0;
      rate_average     <= '0;
      indicator_count  <= '0;
      display_phase    <= '0;
      latched_rate     <= '0;
      cur_signal       <= '0;
      edge_found       <= 1'b0;
      rejected         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // Register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_RATE:       frame_rate       <= cfg_wr_data[FRAME_RATE_W-1:0];
          REG_MIN_RATE:         min_rate         <= cfg_wr_data[RATE_W-1:0];
          REG_MAX_RATE:         max_rate         <= cfg_wr_data[RATE_W-1:0];
          REG_FIRST_EDGE_FRAME: first_edge_frame <= cfg_wr_data[FIRST_W-1:0];
          REG_INDICATOR_FRAMES: indicator_frames <= cfg_wr_data[IND_W-1:0];
          REG_AVERAGE_WEIGHT:   average_weight   <= cfg_wr_data[WEIGHT_W-1:0];
          REG_DISPLAY_PERIOD:   display_period   <= cfg_wr_data[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end

      // Load or drain the result register
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end

      case (ctrl.op)
        OP_CAPTURE: begin
          if (accept) begin
            cur_signal <= pulse_in.peak_signal;
            edge_found <= edge_now;
            rejected   <= 1'b0;
          end
        end
        OP_JUDGE: begin
          rejected <= rate_bad;
        end
        OP_ACCEPT: begin
          indicator_count <= indicator_frames;
          // First accepted rate seeds the average
          if (!average_ready) begin
            rate_average  <= rate;
            average_ready <= 1'b1;
          end
        end
        OP_AVG_ADD: begin
          rate_average <= avg_sum[WEIGHT_W +: RATE_W];
        end
        OP_FIRST: begin
          indicator_count <= indicator_frames;
          have_edge       <= 1'b1;
        end
        OP_FINISH: begin
          if (finish) begin
            if (edge_found) begin
              last_edge_frame <= frame_index;
            end
            previous_signal <= cur_signal;
            latched_rate    <= latch_value;
            display_phase   <= (phase_inc >= {1'b0, period}) ? '0
                                                             : phase_inc[PERIOD_W-1:0];
            if (ind_on) begin
              indicator_count <= indicator_count - 1'b1;
            end
            frame_index     <= frame_index + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      o_indicator_on  <= ind_on;
      o_rate_estimate <= rate_average;
      o_shown_rate    <= latch_value;
      o_edge_seen     <= edge_found;
      o_edge_rejected <= rejected;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.indicator_on  = o_indicator_on;
  assign result_out.rate_estimate = o_rate_estimate;
  assign result_out.shown_rate    = o_shown_rate;
  assign result_out.shown_ready   = (o_shown_rate != '0);
  assign result_out.edge_seen     = o_edge_seen;
  assign result_out.edge_rejected = o_edge_rejected;

`ifndef SYNTHESIS
  a_reject_needs_edge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_out.edge_rejected) |-> result_out.edge_seen)
    else $error("rejected rate reported without an edge");

  a_average_seeded: assert property (@(posedge clk) disable iff (rst)
    (rate_average != '0) |-> average_ready)
    else $error("average nonzero before it was seeded");

  a_divider_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_STEP) |-> (div_count != '0))
    else $error("divider stepped past its last quotient bit");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_busy && ctrl.op == OP_FINISH) |=> $stable(frame_index))
    else $error("frame state advanced while the result register was full");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pulse_rate_tracker_core. Streams per-frame detector
// values through the input channel with random gaps. A cycle-free model of
// the tracker predicts each frame result, and every result transaction is
// compared field by field. The register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prt_pkg::*;

  localparam int FRAME_W = FRAME_INDEX_WIDTH_DEF;

  // Detector codes besides the peak
  localparam logic [SIGNAL_W-1:0] SIGNAL_NONE    = 2'b00;
  localparam logic [SIGNAL_W-1:0] SIGNAL_DIP     = 2'b11;
  localparam logic [SIGNAL_W-1:0] SIGNAL_INVALID = 2'b10;

  typedef struct packed {
    logic              indicator_on;
    logic [RATE_W-1:0] rate_estimate;
    logic [RATE_W-1:0] shown_rate;
    logic              shown_ready;
    logic              edge_seen;
    logic              edge_rejected;
  } frame_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  prt_in_if  pulse_ch ();
  prt_out_if result_ch ();

  pulse_rate_tracker_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .pulse_in    (pulse_ch),
    .result_out  (result_ch)
  );

  // Register shadow
  logic [FRAME_RATE_W-1:0] frame_rate_reg;
  logic [RATE_W-1:0]       min_rate_reg;
  logic [RATE_W-1:0]       max_rate_reg;
  logic [FIRST_W-1:0]      first_frame_reg;
  logic [IND_W-1:0]        ind_frames_reg;
  logic [WEIGHT_W-1:0]     weight_reg;
  logic [PERIOD_W-1:0]     period_reg;

  // Tracker state mirror
  logic [SIGNAL_W-1:0] prev_signal;
  logic [FRAME_W-1:0]  frame_count;
  logic [FRAME_W-1:0]  last_edge_at;
  logic                edge_known;
  logic                avg_seeded;
  logic [RATE_W-1:0]   avg_rate;
  logic [IND_W-1:0]    ind_count;
  logic [PERIOD_W-1:0] disp_phase;
  logic [RATE_W-1:0]   held_rate;

  logic [SIGNAL_W-1:0] peak_queue[$];
  frame_result_t       predicted_frames[$];

  int  frames_queued = 0;
  int  frames_accepted = 0;
  int  mismatches = 0;
  bit  in_busy = 0;
  bit  in_taken = 0;
  bit  out_taken = 0;
  int  in_wait = 0;
  int  out_wait = 0;
  int  in_calm = 0;
  int  out_calm = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Number of idle cycles before the next transaction, with calm stretches
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Beats per minute, UQ14.8, for an edge spacing in frames
  function automatic logic [RATE_W-1:0] pulse_rate(input logic [FRAME_W-1:0] interval);
    logic [63:0] scaled;
    logic [63:0] quot;
    scaled = (64'(SECONDS_PER_MINUTE) * 64'(frame_rate_reg)) << RATE_FRACTION_BITS_DEF;
    if (interval == '0) return RATE_MAX;
    quot = scaled / 64'(interval);
    return (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
  endfunction

  // Advance the tracker mirror by one frame and queue its result
  task automatic predict_frame(input logic [SIGNAL_W-1:0] sig);
    frame_result_t res;
    logic              edge_hit;
    logic              reject;
    logic [RATE_W-1:0] rate;
    logic [63:0]       blend;
    logic [16:0]       next_phase;
    logic [16:0]       period;
    edge_hit = 1'b0;
    reject   = 1'b0;
    if (frame_count >= FRAME_W'(first_frame_reg) && prev_signal != SIGNAL_PEAK &&
        sig == SIGNAL_PEAK) begin
      edge_hit = 1'b1;
      if (edge_known) begin
        rate = pulse_rate(frame_count - last_edge_at);
        if (rate < min_rate_reg || rate > max_rate_reg) begin
          reject = 1'b1;
        end else begin
          ind_count = ind_frames_reg;
          if (avg_seeded) begin
            blend = 64'(weight_reg) * 64'(rate) +
                    (64'd65536 - 64'(weight_reg)) * 64'(avg_rate) + 64'd32768;
            avg_rate = blend[16 +: RATE_W];
          end else begin
            avg_rate   = rate;
            avg_seeded = 1'b1;
          end
        end
      end else begin
        ind_count  = ind_frames_reg;
        edge_known = 1'b1;
      end
      last_edge_at = frame_count;
    end
    prev_signal = sig;

    // Latch the display value at the start of each period
    period = (period_reg == '0) ? 17'd1 : 17'(period_reg);
    if (disp_phase == '0) held_rate = avg_rate;
    next_phase = 17'(disp_phase) + 17'd1;
    disp_phase = (next_phase >= period) ? '0 : next_phase[PERIOD_W-1:0];

    res.indicator_on = (ind_count != '0);
    if (ind_count != '0) ind_count--;
    frame_count++;

    res.rate_estimate = avg_rate;
    res.shown_rate    = held_rate;
    res.shown_ready   = (held_rate != '0);
    res.edge_seen     = edge_hit;
    res.edge_rejected = reject;
    predicted_frames.insert(predicted_frames.size(), res);
  endtask

  function automatic void check_field(input string name, input logic [RATE_W-1:0] want,
                                      input logic [RATE_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Check result transactions, then predict accepted input transactions
  always @(posedge clk) begin : frame_check
    frame_result_t seen;
    frame_result_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        out_taken = 1'b1;
        seen = '{result_ch.indicator_on, result_ch.rate_estimate, result_ch.shown_rate,
                 result_ch.shown_ready, result_ch.edge_seen, result_ch.edge_rejected};
        if (predicted_frames.size() == 0) begin
          $display("%0t ns: result transaction with no prediction pending", $time);
          mismatches++;
        end else begin
          want = predicted_frames.pop_front();
          check_field("indicator_on", RATE_W'(want.indicator_on), RATE_W'(seen.indicator_on));
          check_field("rate_estimate", want.rate_estimate, seen.rate_estimate);
          check_field("shown_rate", want.shown_rate, seen.shown_rate);
          check_field("shown_ready", RATE_W'(want.shown_ready), RATE_W'(seen.shown_ready));
          check_field("edge_seen", RATE_W'(want.edge_seen), RATE_W'(seen.edge_seen));
          check_field("edge_rejected", RATE_W'(want.edge_rejected),
                      RATE_W'(seen.edge_rejected));
        end
      end
      if (pulse_ch.valid && pulse_ch.ready) begin
        predict_frame(pulse_ch.peak_signal);
        frames_accepted++;
        in_taken = 1'b1;
      end
    end
  end

  // Drive detector values with a random gap before each transaction
  always @(negedge clk) begin
    if (rst) begin
      pulse_ch.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_busy  = 1'b0;
        in_wait  = draw_wait(in_calm);
      end
      if (!in_busy) begin
        if (in_wait > 0) begin
          in_wait--;
          pulse_ch.valid <= 1'b0;
        end else if (peak_queue.size() > 0) begin
          pulse_ch.peak_signal <= peak_queue.pop_front();
          pulse_ch.valid       <= 1'b1;
          in_busy = 1'b1;
        end else begin
          pulse_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel for a random time after each transaction
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait  = draw_wait(out_calm);
    end
    if (out_wait > 0) begin
      out_wait--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic push_frame(input logic [SIGNAL_W-1:0] sig);
    peak_queue.insert(peak_queue.size(), sig);
    frames_queued++;
  endtask

  function automatic logic [SIGNAL_W-1:0] quiet_value();
    case ($urandom_range(0, 5))
      0: return SIGNAL_DIP;
      1: return SIGNAL_INVALID;
      default: return SIGNAL_NONE;
    endcase
  endfunction

  // Queue pulses with random spacing, held peaks and bursts of noise
  task automatic queue_pulse_train(input int frames, input int gap_lo, input int gap_hi);
    int made;
    int span;
    int held;
    made = 0;
    while (made < frames) begin
      if ($urandom_range(0, 9) == 0) begin
        span = $urandom_range(1, 8);
        repeat (span) push_frame(SIGNAL_W'($urandom_range(0, 3)));
      end else begin
        span = $urandom_range(gap_lo, gap_hi);
        held = $urandom_range(0, (span > 3) ? 2 : 0);
        push_frame(SIGNAL_PEAK);
        repeat (held) push_frame(SIGNAL_PEAK);
        repeat (span - 1 - held) push_frame(quiet_value());
      end
      made += span;
    end
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    case (idx)
      REG_FRAME_RATE:       frame_rate_reg  = value[FRAME_RATE_W-1:0];
      REG_MIN_RATE:         min_rate_reg    = value[RATE_W-1:0];
      REG_MAX_RATE:         max_rate_reg    = value[RATE_W-1:0];
      REG_FIRST_EDGE_FRAME: first_frame_reg = value[FIRST_W-1:0];
      REG_INDICATOR_FRAMES: ind_frames_reg  = value[IND_W-1:0];
      REG_AVERAGE_WEIGHT:   weight_reg      = value[WEIGHT_W-1:0];
      REG_DISPLAY_PERIOD:   period_reg      = value[PERIOD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] fr, input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] first,
                                input logic [CFG_DATA_W-1:0] ind, input logic [CFG_DATA_W-1:0] weight,
                                input logic [CFG_DATA_W-1:0] period);
    write_register(REG_FRAME_RATE, fr);
    write_register(REG_MIN_RATE, lo);
    write_register(REG_MAX_RATE, hi);
    write_register(REG_FIRST_EDGE_FRAME, first);
    write_register(REG_INDICATOR_FRAMES, ind);
    write_register(REG_AVERAGE_WEIGHT, weight);
    write_register(REG_DISPLAY_PERIOD, period);
  endtask

  // Hold until every queued frame is accepted and every result is back
  task automatic wait_idle();
    @(negedge clk);
    while (frames_accepted != frames_queued || predicted_frames.size() != 0) @(negedge clk);
  endtask

  initial begin
    int          opening [21];
    int          fr;
    int          ilo;
    int          ihi;
    int          scale;
    rst = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wr_data = '0;

    frame_rate_reg  = FRAME_RATE_RST;
    min_rate_reg    = MIN_RATE_RST;
    max_rate_reg    = MAX_RATE_RST;
    first_frame_reg = FIRST_EDGE_FRAME_RST;
    ind_frames_reg  = INDICATOR_FRAMES_RST;
    weight_reg      = AVERAGE_WEIGHT_RST;
    period_reg      = DISPLAY_PERIOD_RST;
    prev_signal  = '0;
    frame_count  = '0;
    last_edge_at = '0;
    edge_known   = 1'b0;
    avg_seeded   = 1'b0;
    avg_rate     = '0;
    ind_count    = '0;
    disp_phase   = '0;
    held_rate    = '0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Peak before the first checked frame, first edge, accepted rate that
    // seeds the average, held peak, then two peak onsets too close to accept
    opening = '{1, 0, 1, 0, -1, -2, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, -2, 1, 0, -1, 1};
    foreach (opening[i]) push_frame(SIGNAL_W'(opening[i]));
    queue_pulse_train(250, 6, 50);
    wait_idle();

    // Fastest frame rate, everything accepted, longest display period
    apply_settings(240, 0, RATE_MAX, 1, 15, 65535, 65535);
    queue_pulse_train(200, 2, 20);
    wait_idle();

    // Zero frame rate gives zero rates; period zero latches every frame
    apply_settings(0, 0, 0, 3, 0, 0, 0);
    queue_pulse_train(100, 2, 12);
    wait_idle();

    apply_settings(1, 0, RATE_MAX, 0, 15, 32768, 1);
    queue_pulse_train(100, 2, 30);
    wait_idle();

    // Random settings with a plausible band and pulses around its edges
    repeat (5) begin
      fr    = $urandom_range(1, 240);
      ilo   = $urandom_range(2, 14);
      ihi   = ilo + $urandom_range(4, 40);
      scale = SECONDS_PER_MINUTE * fr * (1 << RATE_FRACTION_BITS_DEF);
      apply_settings(fr, scale / ihi, scale / ilo, $urandom_range(1, 2), $urandom_range(0, 15),
                     $urandom_range(0, 65535), $urandom_range(1, 2 * fr));
      queue_pulse_train(140, (ilo > 4) ? ilo - 2 : 2, ihi + 4);
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (predicted_frames.size() != 0) begin
      $display("%0t ns: %0d predicted results never arrived", $time, predicted_frames.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[pulse_rate_tracker_core] OK");
    end else begin
      $display("[pulse_rate_tracker_core] ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("%0t ns: timeout", $time);
    $display("[pulse_rate_tracker_core] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/prt_pkg.sv
sv/prt_in_if.sv
sv/prt_out_if.sv
sv/prt_sequencer.sv
sv/prt_datapath.sv
sv/pulse_rate_tracker_core.sv
bench/testbench.sv
